>>> rtl/rs1511_pkg.sv
// Package for the RS(15,11) nibble-pair encoder: sizes, the generator
// coefficients, GF(16) multiply and the shared types.
// No dependencies.
`default_nettype none

package rs1511_pkg;

  localparam int unsigned RsN     = 15;
  localparam int unsigned RsK     = 11;
  localparam int unsigned RsPar   = 4;
  localparam int unsigned SymW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 4;
  localparam logic [SymW-1:0] NibMask = 4'h0f;
  localparam logic [SymW-1:0] FieldPoly = 4'h3; // x^4 = x + 1

  // Generator coefficients g0..g3 in value form (alpha^10, ^3, ^6, ^13).
  localparam logic [RsPar-1:0][SymW-1:0] GenCoef = {4'd13, 4'd12, 4'd8, 4'd7};

  typedef logic [RsPar-1:0][SymW-1:0] par_t;
  typedef logic [RsN-1:0][ByteW-1:0]  word_t;

  // Control from the input side to one parity register.
  typedef struct packed {
    logic step;
    logic clear;
  } lfsr_ctrl_t;

  // Shift-and-add multiply in GF(16), field polynomial x^4+x+1.
  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                             input logic [SymW-1:0] b);
    logic [SymW-1:0] acc;
    logic [SymW-1:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < SymW; i++) begin
      if (b[i]) acc = acc ^ sh;
      sh = sh[SymW-1] ? ({sh[SymW-2:0], 1'b0} ^ FieldPoly) : {sh[SymW-2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rs1511_lfsr.sv
// Four-stage GF(16) parity shift register for one nibble lane.
// Depends on rs1511_pkg.
`default_nettype none

module rs1511_lfsr
  import rs1511_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lfsr_ctrl_t      ctrl_i,
  input  wire logic [SymW-1:0] sym_i,
  output par_t                 par_next_o
);

  par_t            par_q;
  par_t            par_d;
  logic [SymW-1:0] fb;

  // Form the stepped parity from the feedback symbol
  always_comb begin
    fb            = (sym_i ^ par_q[RsPar-1]) & NibMask;
    par_next_o[0] = gf_mul(fb, GenCoef[0]);
    for (int j = 1; j < RsPar; j++) begin
      par_next_o[j] = par_q[j-1] ^ gf_mul(fb, GenCoef[j]);
    end
  end

  // Advance on a word, drop to zero when the codeword is complete
  always_comb begin
    par_d = par_q;
    if (ctrl_i.step) begin
      par_d = ctrl_i.clear ? '0 : par_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= '0;
    end else begin
      par_q <= par_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rs1511_obuf.sv
// Output bank: holds one finished codeword and shifts it out word by word.
// Depends on rs1511_pkg.
`default_nettype none

module rs1511_obuf
  import rs1511_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire word_t            word_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [ByteW-1:0]      code_byte_o,
  output logic [CntW-1:0]       code_index_o,
  output logic                  last_of_word_o,
  output logic                  busy_o,
  output logic                  finish_o
);

  localparam logic [CntW-1:0] LastIdx = CntW'(RsN - 1);

  word_t           bank_q, bank_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            fire;

  assign fire     = busy_q && !out_stall_i;
  assign finish_o = fire && (idx_q == LastIdx);

  // Load a new codeword, or shift the bank on each taken word
  always_comb begin
    bank_d = bank_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load_i) begin
      bank_d = word_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (fire) begin
      bank_d = bank_q >> ByteW;
      idx_d  = idx_q + 1'b1;
      if (idx_q == LastIdx) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
  end

  assign out_valid_o    = busy_q;
  assign code_byte_o    = bank_q[0];
  assign code_index_o   = idx_q;
  assign last_of_word_o = busy_q && (idx_q == LastIdx);
  assign busy_o         = busy_q;

endmodule

`default_nettype wire

>>> rtl/rs15_11_nibble_pair_encoder_top.sv
// Two interleaved RS(15,11) encoders over GF(16), one per nibble of each byte.
// Input word: one data byte, highest data index first, eleven per codeword.
// Output word: code byte, its index in the codeword and a last flag.
// Each accepted byte steps both parity registers in the same cycle and is
// stored. The eleventh byte moves the four parity bytes and the eleven data
// bytes into the output bank, which presents fifteen words from the next
// cycle on: parity 0..3, then data index 0..10; last_of_word_o marks index 14.
// Throughput: one input byte per cycle unless in_stall_o holds it; the single
// output port presents the fifteen bytes of a codeword one by one. The
// eleventh byte of the next word waits (in_stall_o high) while the bank
// still holds an unfinished codeword; the other ten never wait.
// When the receiver stalls, the current code word holds on the outputs.
// Reset clears parity, the byte count and the output bank's valid state.
// Depends on rs1511_pkg, rs1511_lfsr and rs1511_obuf.
`default_nettype none

module rs15_11_nibble_pair_encoder_top
  import rs1511_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      code_byte_o,
  output logic [CntW-1:0]       code_index_o,
  output logic                  last_of_word_o
);

  localparam logic [CntW-1:0] LastCnt = CntW'(RsK - 1);

  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [RsK-1:0][ByteW-1:0]   store_q;
  logic [CntW-1:0]             pos;
  logic                        in_fire;
  logic                        complete;
  logic                        bank_busy;
  logic                        bank_finish;
  lfsr_ctrl_t                  lfsr_ctrl;
  par_t                        par_lo, par_hi;
  word_t                       word;

  // Hold the closing byte while the bank is still draining
  assign in_stall_o = (cnt_q == LastCnt) && bank_busy && !bank_finish;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign complete   = in_fire && (cnt_q == LastCnt);
  assign pos        = LastCnt - cnt_q;

  assign lfsr_ctrl.step  = in_fire;
  assign lfsr_ctrl.clear = complete;

  // Count bytes of the current codeword
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) cnt_d = complete ? '0 : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Store data bytes by data index
  always_ff @(posedge clk_i) begin
    if (in_fire) store_q[pos] <= data_byte_i;
  end

  rs1511_lfsr u_lfsr_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lfsr_ctrl),
    .sym_i      (data_byte_i[SymW-1:0]),
    .par_next_o (par_lo)
  );

  rs1511_lfsr u_lfsr_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lfsr_ctrl),
    .sym_i      (data_byte_i[ByteW-1:SymW]),
    .par_next_o (par_hi)
  );

  // Assemble the codeword: parity pairs, current byte at data index 0, rest
  always_comb begin
    for (int i = 0; i < RsPar; i++) begin
      word[i] = {par_hi[i], par_lo[i]};
    end
    word[RsPar] = data_byte_i;
    for (int k = 1; k < RsK; k++) begin
      word[RsPar+k] = store_q[k];
    end
  end

  rs1511_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (complete),
    .word_i         (word),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .code_byte_o    (code_byte_o),
    .code_index_o   (code_index_o),
    .last_of_word_o (last_of_word_o),
    .busy_o         (bank_busy),
    .finish_o       (bank_finish)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_rs15_11_nibble_pair_encoder_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RS(15,11) nibble-pair encoder top level.
// Drives data bytes, predicts each codeword in GF(16) and checks every code word.
// Depends on rs1511_pkg and rs15_11_nibble_pair_encoder_top.

module tb_rs15_11_nibble_pair_encoder_top;
  import rs1511_pkg::*;

  localparam int DIRECTED_WORDS = 2;
  localparam int RANDOM_WORDS   = 39;
  localparam int TOTAL_BYTES    = (DIRECTED_WORDS + RANDOM_WORDS) * RsK;
  localparam int QUIET_BYTES    = 8 * RsK;
  localparam int PRESSURE_AT    = 120;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 200000;

  // GF(16) antilog / log tables, field polynomial x^4+x+1, alpha = 2
  localparam logic [0:15][3:0] ALPHA_POW = {4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
                                            4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9, 4'd0};
  localparam logic [0:15][3:0] ALPHA_LOG = {4'd0, 4'd0, 4'd1, 4'd4, 4'd2, 4'd8, 4'd5, 4'd10,
                                            4'd3, 4'd14, 4'd9, 4'd7, 4'd6, 4'd13, 4'd11, 4'd12};
  // generator coefficients g0..g4 as powers of alpha
  localparam logic [0:4][3:0]  GEN_LOG   = {4'd10, 4'd3, 4'd6, 4'd13, 4'd0};

  // mixed corner bytes for the first directed codeword
  localparam logic [0:10][7:0] MIXED_WORD = {8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h80,
                                             8'h55, 8'hAA, 8'h7E, 8'h10, 8'h00};

  typedef enum int {FILL_UNIFORM, FILL_CORNER, FILL_SPARSE} fill_e;

  typedef struct packed {
    logic [ByteW-1:0] code;
    logic [CntW-1:0]  index;
    logic             last;
  } code_word_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic [ByteW-1:0] data_byte_i    = '0;
  logic             out_stall_i    = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [ByteW-1:0] code_byte_o;
  logic [CntW-1:0]  code_index_o;
  logic             last_of_word_o;

  logic [ByteW-1:0] pending_bytes[$];
  code_word_t       expected_codes[$];

  // encoder state as predicted
  logic [ByteW-1:0] parity_bytes [RsPar];
  logic [ByteW-1:0] data_by_index [RsK];
  int               bytes_in_word  = 0;

  logic byte_taken    = 1'b0;
  int   bytes_accepted = 0;
  int   error_count    = 0;
  int   send_gap       = 0;
  int   stall_left     = 0;
  int   hold_left      = 0;
  bit   pressure_done  = 1'b0;
  int   cycle_count;

  rs15_11_nibble_pair_encoder_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_byte_o    (code_byte_o),
    .code_index_o   (code_index_o),
    .last_of_word_o (last_of_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit quiet_phase();
    return bytes_accepted >= TOTAL_BYTES - QUIET_BYTES;
  endfunction

  // Advance one four-stage parity register by one data symbol.
  function automatic par_t advance_parity(input par_t regs, input logic [SymW-1:0] sym);
    par_t            nxt;
    logic [SymW-1:0] fb;
    int              e;
    nxt = '0;
    fb  = sym ^ regs[RsPar-1];
    if (fb != '0) begin
      e = ALPHA_LOG[fb];
      for (int j = RsPar - 1; j > 0; j--) begin
        nxt[j] = regs[j-1] ^ ALPHA_POW[(GEN_LOG[j] + e) % RsN];
      end
      nxt[0] = ALPHA_POW[(GEN_LOG[0] + e) % RsN];
    end else begin
      // zero feedback: plain shift, zero into the lowest stage
      for (int j = RsPar - 1; j > 0; j--) begin
        nxt[j] = regs[j-1];
      end
    end
    return nxt;
  endfunction

  // Take one data byte into both codes; queue the codeword on the eleventh.
  task automatic absorb_data_byte(input logic [ByteW-1:0] b);
    par_t       lo_syms;
    par_t       hi_syms;
    code_word_t cw;
    for (int i = 0; i < RsPar; i++) begin
      lo_syms[i] = parity_bytes[i][3:0];
      hi_syms[i] = parity_bytes[i][7:4];
    end
    data_by_index[RsK - 1 - bytes_in_word] = b;
    lo_syms = advance_parity(lo_syms, b[3:0]);
    hi_syms = advance_parity(hi_syms, b[7:4]);
    for (int i = 0; i < RsPar; i++) begin
      parity_bytes[i] = {hi_syms[i], lo_syms[i]};
    end
    bytes_in_word++;
    if (bytes_in_word == RsK) begin
      for (int i = 0; i < RsN; i++) begin
        cw.code  = (i < RsPar) ? parity_bytes[i] : data_by_index[i - RsPar];
        cw.index = CntW'(i);
        cw.last  = (i == RsN - 1);
        expected_codes.push_back(cw);
      end
      for (int i = 0; i < RsPar; i++) begin
        parity_bytes[i] = '0;
      end
      bytes_in_word = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Compare one accepted code word with the oldest expectation.
  task automatic check_code_word();
    code_word_t want;
    if (expected_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected word: byte %02h index %0d last %0b",
                                code_byte_o, code_index_o, last_of_word_o));
      return;
    end
    want = expected_codes.pop_front();
    if (code_byte_o !== want.code)
      report_mismatch($sformatf("code_byte at index %0d: got %02h, want %02h",
                                want.index, code_byte_o, want.code));
    if (code_index_o !== want.index)
      report_mismatch($sformatf("code_index: got %0d, want %0d", code_index_o, want.index));
    if (last_of_word_o !== want.last)
      report_mismatch($sformatf("last_of_word at index %0d: got %0b, want %0b",
                                want.index, last_of_word_o, want.last));
  endtask

  function automatic logic [ByteW-1:0] pick_data_byte(input fill_e style);
    logic [ByteW-1:0] b;
    b = ByteW'($urandom);
    case (style)
      FILL_CORNER: begin
        case ($urandom_range(0, 4))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = 8'h0F;
          3: b = 8'hF0;
          default: ;
        endcase
      end
      FILL_SPARSE: begin
        if ($urandom_range(0, 2) != 0) b = 8'h00;
      end
      default: ;
    endcase
    return b;
  endfunction

  // Sample both handshakes: predict on input words, check output words.
  always @(posedge clk_i) begin
    byte_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        absorb_data_byte(data_byte_i);
        bytes_accepted++;
      end
      if (out_valid_o && !out_stall_i) check_code_word();
    end
  end

  // Offer data bytes; hold a stalled word, insert random idle bursts.
  always @(negedge clk_i) begin : drive_bytes
    logic             nxt_valid;
    logic [ByteW-1:0] nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = data_byte_i;
    if (rst_ni) begin
      if (byte_taken) begin
        void'(pending_bytes.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0) begin
          if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 5);
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = pending_bytes[0];
          end
        end
      end
    end
    in_valid_i  <= nxt_valid;
    data_byte_i <= nxt_data;
  end

  // Drive the output stall: random bursts plus one long hold to back up the block.
  always @(negedge clk_i) begin : drive_stall
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst_ni) begin
      if (!pressure_done && bytes_accepted >= PRESSURE_AT) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        nxt_stall  = 1'b1;
      end
    end
    out_stall_i <= nxt_stall;
  end

  // Build the byte stream, release reset, wait for the drain, report.
  initial begin : stimulus
    fill_e style;
    int    pick;
    for (int i = 0; i < RsPar; i++) parity_bytes[i] = '0;
    for (int i = 0; i < RsK; i++) data_by_index[i] = '0;
    // corner bytes, then an all-zero word where feedback stays zero
    for (int i = 0; i < RsK; i++) pending_bytes.push_back(MIXED_WORD[i]);
    for (int i = 0; i < RsK; i++) pending_bytes.push_back(8'h00);
    for (int w = 0; w < RANDOM_WORDS; w++) begin
      pick  = $urandom_range(0, 9);
      style = (pick < 6) ? FILL_UNIFORM : (pick < 8) ? FILL_CORNER : FILL_SPARSE;
      for (int i = 0; i < RsK; i++) pending_bytes.push_back(pick_data_byte(style));
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/rs1511_pkg.sv
rtl/rs1511_lfsr.sv
rtl/rs1511_obuf.sv
rtl/rs15_11_nibble_pair_encoder_top.sv
tb/sv/tb_rs15_11_nibble_pair_encoder_top.sv
